FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/crc16r_pkg.sv
package crc16r_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Contents of the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } stage_t;

  // Fold one byte into the running CRC, LSB first
  function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ b[k]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // Final value: complement, then swap bytes
  function automatic logic [15:0] crc_finish(input logic [15:0] crc);
    logic [15:0] inv;
    inv = ~crc;
    return {inv[7:0], inv[15:8]};
  endfunction

endpackage

FILE: rtl/crc16r_if.sv
// Byte channel into the block
interface crc16r_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel out of the block
interface crc16r_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

FILE: rtl/crc16r_in_stage.sv
module crc16r_in_stage (
  input  logic              clk,
  input  logic              rst,
  crc16r_in_if.sink         msg,
  input  logic              adv,
  output crc16r_pkg::stage_t s1
);
  import crc16r_pkg::*;

  stage_t stage;
  logic   take;

  // Register is free when empty or draining this cycle
  assign msg.ready = !stage.valid || adv;
  assign take      = msg.valid && msg.ready;
  assign s1        = stage;

  // Valid flag under reset, payload without
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (take) begin
      stage.valid <= 1'b1;
    end else if (adv) begin
      stage.valid <= 1'b0;
    end
    if (take) begin
      stage.data <= msg.data_byte;
      stage.last <= msg.last_byte;
    end
  end

endmodule

FILE: rtl/crc16r_core.sv
module crc16r_core (
  input  logic               clk,
  input  logic               rst,
  input  crc16r_pkg::stage_t s1,
  input  logic               out_free,
  output logic               adv,
  output logic               load,
  output logic [15:0]        result
);
  import crc16r_pkg::*;

  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [15:0] folded;

  // A last word waits for room in the result register
  assign adv    = s1.valid && (!s1.last || out_free);
  assign load   = adv && s1.last;
  assign folded = crc_fold(crc, s1.data);
  assign result = crc_finish(folded);

  always_comb begin
    crc_next = crc;
    if (adv) begin
      crc_next = s1.last ? CRC_INIT : folded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else begin
      crc <= crc_next;
    end
  end

endmodule

FILE: rtl/crc16r_out_stage.sv
module crc16r_out_stage (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  logic [15:0]  result,
  output logic         out_free,
  crc16r_out_if.source crc
);

  logic        valid;
  logic [15:0] value;

  // Free when empty or being taken now
  assign out_free      = !valid || crc.ready;
  assign crc.valid     = valid;
  assign crc.crc_value = value;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (crc.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value <= result;
    end
  end

endmodule

FILE: rtl/crc16_reflected_byte_stream.sv
// CRC-16 (reflected poly 0xA001, init 0xFFFF) over a byte stream.
// Throughput: one byte per cycle, sustained while the result side keeps up.
// The last byte passes the input register, then the result register, where
// the result is presented; the fold is combinational logic between the two.
// Reset (rst, synchronous) empties both registers and sets the CRC to 0xFFFF.
module crc16_reflected_byte_stream (
  input  logic         clk,
  input  logic         rst,
  crc16r_in_if.sink    msg,
  crc16r_out_if.source crc
);
  import crc16r_pkg::*;

  stage_t      s1;
  logic        adv;
  logic        load;
  logic        out_free;
  logic [15:0] result;

  crc16r_in_stage u_in (
    .clk (clk),
    .rst (rst),
    .msg (msg),
    .adv (adv),
    .s1  (s1)
  );

  crc16r_core u_core (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .out_free (out_free),
    .adv      (adv),
    .load     (load),
    .result   (result)
  );

  crc16r_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .result   (result),
    .out_free (out_free),
    .crc      (crc)
  );

  // Checks
  `include "assert_macros.svh"

  `ASSERT_NEXT(a_load_shows, clk, rst, load, crc.valid, "finished word not presented")
  `ASSERT_NEXT(a_take_fills, clk, rst, msg.valid && msg.ready, s1.valid, "accepted byte lost")
  `ASSERT_NOW(a_stall_blocks, clk, rst, s1.valid && s1.last && !out_free, !msg.ready && !adv, "last byte passed a full result register")

endmodule
